// File: sv/ppct_pkg.sv
// Shared types and constants for the primitive pair collision test.
// Used by the front end, the square root and divider pipelines and the top level.
// No dependencies.
package ppct_pkg;

    // Default parameter values
    localparam int COORD_WIDTH_DEF = 24;
    localparam int NORMAL_FRAC_DEF = 14;

    // Normalized vector magnitudes keep their top set bit at bit NRM_W-1
    localparam int NRM_W    = 24;
    // Sum of two normalized squares and its floor square root
    localparam int SQ_W     = 2 * NRM_W + 1;
    localparam int LEN_W    = NRM_W + 1;
    localparam int SQ_STEPS = LEN_W;

    // Pair type selector
    typedef enum logic [1:0] {
        CMD_CIRCLE     = 2'd0,
        CMD_BOX        = 2'd1,
        CMD_BOX_CIRCLE = 2'd2,
        CMD_RESERVED   = 2'd3
    } t_cmd;

    // Axis-aligned normal component
    typedef enum logic [1:0] {
        AX_ZERO = 2'd0,
        AX_POS  = 2'd1,
        AX_NEG  = 2'd2
    } t_axdir;

    // Per-item decision carried alongside the normalization datapath
    typedef struct packed {
        logic   hit;
        logic   use_unit;
        logic   neg_x;
        logic   neg_y;
        t_axdir fix_x;
        t_axdir fix_y;
    } t_meta;

endpackage

// File: sv/ppct_front.sv
// Front end: differences, clamping, squared distances, collision decision
// and normalization of the normal vector to a fixed leading bit. Seven stages.
// Depends on ppct_pkg.
module ppct_front import ppct_pkg::*; #(
    parameter int CW = COORD_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  t_cmd                 i_cmd,
    input  logic signed [CW-1:0] i_x1,
    input  logic signed [CW-1:0] i_y1,
    input  logic signed [CW-1:0] i_x2,
    input  logic signed [CW-1:0] i_y2,
    input  logic [CW-2:0]        i_hw1,
    input  logic [CW-2:0]        i_hh1,
    input  logic [CW-2:0]        i_hw2,
    input  logic [CW-2:0]        i_hh2,
    output logic                 o_valid,
    output logic [SQ_W-1:0]      o_len_sq,
    output logic [NRM_W-1:0]     o_ux,
    output logic [NRM_W-1:0]     o_uy,
    output t_meta                o_meta
);

    localparam int DW  = CW + 1;
    localparam int TW  = CW + 2;
    localparam int MW  = CW;
    localparam int PW  = 2 * MW;
    localparam int LZW = $clog2(MW);

    // ---------------- stage 1: center differences and extent sums
    logic                 r1_valid;
    t_cmd                 r1_cmd;
    logic signed [DW-1:0] r1_dx, r1_dy, n1_dx, n1_dy;
    logic [CW-2:0]        r1_hw1, r1_hh1, r1_hw2;
    logic [CW-1:0]        r1_wsum, r1_hsum, r1_hsum2;

    always_comb begin
        if (i_cmd == CMD_CIRCLE) begin
            n1_dx = $signed({i_x1[CW-1], i_x1}) - $signed({i_x2[CW-1], i_x2});
            n1_dy = $signed({i_y1[CW-1], i_y1}) - $signed({i_y2[CW-1], i_y2});
        end else begin
            n1_dx = $signed({i_x2[CW-1], i_x2}) - $signed({i_x1[CW-1], i_x1});
            n1_dy = $signed({i_y2[CW-1], i_y2}) - $signed({i_y1[CW-1], i_y1});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_cmd   <= i_cmd;
            r1_dx    <= n1_dx;
            r1_dy    <= n1_dy;
            r1_hw1   <= i_hw1;
            r1_hh1   <= i_hh1;
            r1_hw2   <= i_hw2;
            r1_wsum  <= {1'b0, i_hw1} + {1'b0, i_hw2};
            r1_hsum  <= {1'b0, i_hh1} + {1'b0, i_hh2};
            r1_hsum2 <= {1'b0, i_hh1} + {1'b0, i_hw2};
        end
    end

    // ---------------- stage 2: magnitudes and clamped offsets
    logic                 r2_valid;
    t_cmd                 r2_cmd;
    logic [MW-1:0]        r2_ax, r2_ay, n2_ax, n2_ay;
    logic                 r2_sdx, r2_sdy;
    logic signed [DW-1:0] r2_vx, r2_vy, n2_vx, n2_vy;
    logic [CW-2:0]        r2_hw2;
    logic [CW-1:0]        r2_wsum, r2_hsum, r2_hsum2;
    logic signed [TW-1:0] n2_t1x, n2_t2x, n2_t1y, n2_t2y, n2_ex, n2_ey;

    always_comb begin
        n2_ax  = r1_dx[DW-1] ? MW'(-r1_dx) : MW'(r1_dx);
        n2_ay  = r1_dy[DW-1] ? MW'(-r1_dy) : MW'(r1_dy);
        // closest point minus center, per axis
        n2_t1x = $signed({3'b000, r1_hw1}) - TW'(r1_dx);
        n2_t2x = -($signed({3'b000, r1_hw1}) + TW'(r1_dx));
        n2_t1y = $signed({3'b000, r1_hh1}) - TW'(r1_dy);
        n2_t2y = -($signed({3'b000, r1_hh1}) + TW'(r1_dy));
        n2_ex  = n2_t1x[TW-1] ? n2_t1x : (n2_t2x > 0) ? n2_t2x : '0;
        n2_ey  = n2_t1y[TW-1] ? n2_t1y : (n2_t2y > 0) ? n2_t2y : '0;
        n2_vx  = (r1_cmd == CMD_CIRCLE) ? r1_dx : DW'(n2_ex);
        n2_vy  = (r1_cmd == CMD_CIRCLE) ? r1_dy : DW'(n2_ey);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_cmd   <= r1_cmd;
            r2_ax    <= n2_ax;
            r2_ay    <= n2_ay;
            r2_sdx   <= r1_dx[DW-1];
            r2_sdy   <= r1_dy[DW-1];
            r2_vx    <= n2_vx;
            r2_vy    <= n2_vy;
            r2_hw2   <= r1_hw2;
            r2_wsum  <= r1_wsum;
            r2_hsum  <= r1_hsum;
            r2_hsum2 <= r1_hsum2;
        end
    end

    // ---------------- stage 3: vector magnitudes and penetration depths
    logic                 r3_valid;
    t_cmd                 r3_cmd;
    logic [MW-1:0]        r3_mx, r3_my;
    logic                 r3_svx, r3_svy, r3_sdx, r3_sdy;
    logic signed [TW-1:0] r3_px, r3_py;
    logic [CW-1:0]        r3_rsel, n3_hsel;

    assign n3_hsel = (r2_cmd == CMD_BOX) ? r2_hsum : r2_hsum2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_cmd  <= r2_cmd;
            r3_mx   <= r2_vx[DW-1] ? MW'(-r2_vx) : MW'(r2_vx);
            r3_my   <= r2_vy[DW-1] ? MW'(-r2_vy) : MW'(r2_vy);
            r3_svx  <= r2_vx[DW-1];
            r3_svy  <= r2_vy[DW-1];
            r3_sdx  <= r2_sdx;
            r3_sdy  <= r2_sdy;
            r3_px   <= $signed({2'b00, r2_wsum}) - $signed({2'b00, r2_ax});
            r3_py   <= $signed({2'b00, n3_hsel}) - $signed({2'b00, r2_ay});
            r3_rsel <= (r2_cmd == CMD_CIRCLE) ? r2_wsum : {1'b0, r2_hw2};
        end
    end

    // ---------------- stage 4: squares, leading zero count, box compares
    logic                 r4_valid;
    t_cmd                 r4_cmd;
    logic [PW-1:0]        r4_sqx, r4_sqy, r4_rr;
    logic [MW-1:0]        r4_mx, r4_my, n4_orv;
    logic [LZW-1:0]       r4_lz, n4_lz;
    logic                 r4_zero, r4_bhit, r4_pxlt;
    logic                 r4_svx, r4_svy, r4_sdx, r4_sdy;

    assign n4_orv = r3_mx | r3_my;

    // The top set bit of the larger magnitude is the top set bit of the OR
    always_comb begin
        n4_lz = '0;
        for (int i = 0; i < MW; i++) begin
            if (n4_orv[i]) begin
                n4_lz = LZW'(MW - 1 - i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_cmd  <= r3_cmd;
            r4_sqx  <= PW'(r3_mx) * PW'(r3_mx);
            r4_sqy  <= PW'(r3_my) * PW'(r3_my);
            r4_rr   <= PW'(r3_rsel) * PW'(r3_rsel);
            r4_mx   <= r3_mx;
            r4_my   <= r3_my;
            r4_lz   <= n4_lz;
            r4_zero <= (n4_orv == '0);
            r4_bhit <= (r3_px > 0) && (r3_py > 0);
            r4_pxlt <= (r3_px < r3_py);
            r4_svx  <= r3_svx;
            r4_svy  <= r3_svy;
            r4_sdx  <= r3_sdx;
            r4_sdy  <= r3_sdy;
        end
    end

    // ---------------- stage 5: squared distance, shift to fixed leading bit
    logic                 r5_valid;
    t_cmd                 r5_cmd;
    logic [PW:0]          r5_d2;
    logic [PW-1:0]        r5_rr;
    logic [NRM_W-1:0]     r5_ux, r5_uy, n5_ux, n5_uy;
    logic [MW-1:0]        n5_jx, n5_jy;
    logic                 r5_zero, r5_bhit, r5_pxlt;
    logic                 r5_svx, r5_svy, r5_sdx, r5_sdy;

    assign n5_jx = r4_mx << r4_lz;
    assign n5_jy = r4_my << r4_lz;

    generate
        if (MW >= NRM_W) begin : g_trunc
            assign n5_ux = n5_jx[MW-1 -: NRM_W];
            assign n5_uy = n5_jy[MW-1 -: NRM_W];
        end else begin : g_pad
            assign n5_ux = {n5_jx, {(NRM_W - MW){1'b0}}};
            assign n5_uy = {n5_jy, {(NRM_W - MW){1'b0}}};
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (i_en) begin
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_cmd  <= r4_cmd;
            r5_d2   <= (PW+1)'(r4_sqx) + (PW+1)'(r4_sqy);
            r5_rr   <= r4_rr;
            r5_ux   <= n5_ux;
            r5_uy   <= n5_uy;
            r5_zero <= r4_zero;
            r5_bhit <= r4_bhit;
            r5_pxlt <= r4_pxlt;
            r5_svx  <= r4_svx;
            r5_svy  <= r4_svy;
            r5_sdx  <= r4_sdx;
            r5_sdy  <= r4_sdy;
        end
    end

    // ---------------- stage 6: collision decision, squares of normalized vector
    logic                   r6_valid;
    t_meta                  r6_meta, n6_meta;
    logic [2*NRM_W-1:0]     r6_uxsq, r6_uysq;
    logic [NRM_W-1:0]       r6_ux, r6_uy;
    logic                   n6_d2_lt, n6_rr_lt;

    assign n6_d2_lt = (r5_d2 < {1'b0, r5_rr});
    assign n6_rr_lt = ({1'b0, r5_rr} < r5_d2);

    always_comb begin
        n6_meta       = '0;
        n6_meta.neg_x = r5_svx;
        n6_meta.neg_y = r5_svy;
        case (r5_cmd)
            CMD_CIRCLE: begin
                n6_meta.hit      = n6_d2_lt;
                n6_meta.use_unit = n6_d2_lt && !r5_zero;
            end
            CMD_BOX: begin
                n6_meta.hit = r5_bhit;
                if (r5_bhit) begin
                    if (r5_pxlt) begin
                        n6_meta.fix_x = r5_sdx ? AX_NEG : AX_POS;
                    end else begin
                        n6_meta.fix_y = r5_sdy ? AX_POS : AX_NEG;
                    end
                end
            end
            CMD_BOX_CIRCLE: begin
                n6_meta.hit      = !n6_rr_lt;
                n6_meta.use_unit = !n6_rr_lt && !r5_zero;
                // circle center inside the box: fall back to an axis
                if (!n6_rr_lt && r5_zero) begin
                    if (r5_pxlt) begin
                        n6_meta.fix_x = r5_sdx ? AX_POS : AX_NEG;
                    end else begin
                        n6_meta.fix_y = r5_sdy ? AX_POS : AX_NEG;
                    end
                end
            end
            default: begin
                n6_meta.hit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else if (i_en) begin
            r6_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_meta <= n6_meta;
            r6_uxsq <= (2*NRM_W)'(r5_ux) * (2*NRM_W)'(r5_ux);
            r6_uysq <= (2*NRM_W)'(r5_uy) * (2*NRM_W)'(r5_uy);
            r6_ux   <= r5_ux;
            r6_uy   <= r5_uy;
        end
    end

    // ---------------- stage 7: squared length of normalized vector
    logic               r7_valid;
    t_meta              r7_meta;
    logic [SQ_W-1:0]    r7_len_sq;
    logic [NRM_W-1:0]   r7_ux, r7_uy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_valid <= 1'b0;
        end else if (i_en) begin
            r7_valid <= r6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_meta   <= r6_meta;
            r7_len_sq <= SQ_W'(r6_uxsq) + SQ_W'(r6_uysq);
            r7_ux     <= r6_ux;
            r7_uy     <= r6_uy;
        end
    end

    assign o_valid  = r7_valid;
    assign o_len_sq = r7_len_sq;
    assign o_ux     = r7_ux;
    assign o_uy     = r7_uy;
    assign o_meta   = r7_meta;

endmodule

// File: sv/ppct_sqrt.sv
// Pipelined floor square root, one result bit per stage.
// Carries the normalized vector and the item decision alongside.
// Depends on ppct_pkg.
module ppct_sqrt import ppct_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [SQ_W-1:0]   i_len_sq,
    input  logic [NRM_W-1:0]  i_ux,
    input  logic [NRM_W-1:0]  i_uy,
    input  t_meta             i_meta,
    output logic              o_valid,
    output logic [LEN_W-1:0]  o_len,
    output logic [NRM_W-1:0]  o_ux,
    output logic [NRM_W-1:0]  o_uy,
    output t_meta             o_meta
);

    localparam int K = SQ_STEPS;

    // Stage inputs: index 0 is the port side, index s+1 is stage s's register
    logic [SQ_W-1:0]  a_rem [0:K];
    logic [SQ_W-1:0]  a_root[0:K];
    logic [NRM_W-1:0] a_ux  [0:K];
    logic [NRM_W-1:0] a_uy  [0:K];
    t_meta            a_meta[0:K];
    logic             a_vld [0:K];

    logic [SQ_W-1:0]  r_rem [0:K-1];
    logic [SQ_W-1:0]  r_root[0:K-1];
    logic [NRM_W-1:0] r_ux  [0:K-1];
    logic [NRM_W-1:0] r_uy  [0:K-1];
    t_meta            r_meta[0:K-1];
    logic             r_vld [0:K-1];

    assign a_rem[0]  = i_len_sq;
    assign a_root[0] = '0;
    assign a_ux[0]   = i_ux;
    assign a_uy[0]   = i_uy;
    assign a_meta[0] = i_meta;
    assign a_vld[0]  = i_valid;

    genvar s;
    generate
        for (s = 0; s < K; s++) begin : g_stage
            localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (K - 1 - s));
            logic [SQ_W:0]   n_trial;
            logic            n_take;
            logic [SQ_W-1:0] n_rem, n_root;

            // Try subtracting root + bit, keep the remainder if it fits
            always_comb begin
                n_trial = {1'b0, a_root[s]} + {1'b0, BIT};
                n_take  = ({1'b0, a_rem[s]} >= n_trial);
                n_rem   = n_take ? (a_rem[s] - n_trial[SQ_W-1:0]) : a_rem[s];
                n_root  = n_take ? ((a_root[s] >> 1) + BIT) : (a_root[s] >> 1);
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[s] <= 1'b0;
                end else if (i_en) begin
                    r_vld[s] <= a_vld[s];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s]  <= n_rem;
                    r_root[s] <= n_root;
                    r_ux[s]   <= a_ux[s];
                    r_uy[s]   <= a_uy[s];
                    r_meta[s] <= a_meta[s];
                end
            end

            assign a_rem[s+1]  = r_rem[s];
            assign a_root[s+1] = r_root[s];
            assign a_ux[s+1]   = r_ux[s];
            assign a_uy[s+1]   = r_uy[s];
            assign a_meta[s+1] = r_meta[s];
            assign a_vld[s+1]  = r_vld[s];
        end
    endgenerate

    assign o_valid = a_vld[K];
    assign o_len   = a_root[K][LEN_W-1:0];
    assign o_ux    = a_ux[K];
    assign o_uy    = a_uy[K];
    assign o_meta  = a_meta[K];

endmodule

// File: sv/ppct_div.sv
// Pipelined rounded division of both normalized components by the length,
// one quotient bit per stage after a setup stage that adds half the length.
// Depends on ppct_pkg.
module ppct_div import ppct_pkg::*; #(
    parameter int NF = NORMAL_FRAC_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [LEN_W-1:0]  i_len,
    input  logic [NRM_W-1:0]  i_ux,
    input  logic [NRM_W-1:0]  i_uy,
    input  t_meta             i_meta,
    output logic              o_valid,
    output logic [NF:0]       o_qx,
    output logic [NF:0]       o_qy,
    output t_meta             o_meta
);

    localparam int NS = NF + 1;
    localparam int DW = NRM_W + NF + 1;

    // One restoring step: returns {quotient bit, new remainder}
    function automatic logic [LEN_W:0] div_step(input logic [LEN_W-1:0] rem,
                                                input logic             b,
                                                input logic [LEN_W-1:0] len);
        logic [LEN_W:0] t;
        logic           ge;
        t  = {rem, b};
        ge = (t >= {1'b0, len});
        if (ge) begin
            t = t - {1'b0, len};
        end
        return {ge, t[LEN_W-1:0]};
    endfunction

    // ---------------- setup: numerator = u * 2^NF + floor(len / 2)
    logic [DW-1:0] n0_numx, n0_numy;
    logic          r0_vld;
    logic [LEN_W-1:0] r0_remx, r0_remy, r0_len;
    logic [NF:0]   r0_lox, r0_loy;
    t_meta         r0_meta;

    assign n0_numx = {1'b0, i_ux, {NF{1'b0}}} + DW'(i_len >> 1);
    assign n0_numy = {1'b0, i_uy, {NF{1'b0}}} + DW'(i_len >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (i_en) begin
            r0_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_remx <= LEN_W'(n0_numx[DW-1:NF+1]);
            r0_remy <= LEN_W'(n0_numy[DW-1:NF+1]);
            r0_lox  <= n0_numx[NF:0];
            r0_loy  <= n0_numy[NF:0];
            r0_len  <= i_len;
            r0_meta <= i_meta;
        end
    end

    // ---------------- quotient bit stages
    logic [LEN_W-1:0] a_remx[0:NS], a_remy[0:NS], a_len[0:NS];
    logic [NF:0]      a_lox [0:NS], a_loy [0:NS], a_qx[0:NS], a_qy[0:NS];
    t_meta            a_meta[0:NS];
    logic             a_vld [0:NS];

    logic [LEN_W-1:0] r_remx[0:NS-1], r_remy[0:NS-1], r_len[0:NS-1];
    logic [NF:0]      r_lox [0:NS-1], r_loy [0:NS-1], r_qx[0:NS-1], r_qy[0:NS-1];
    t_meta            r_meta[0:NS-1];
    logic             r_vld [0:NS-1];

    assign a_remx[0] = r0_remx;
    assign a_remy[0] = r0_remy;
    assign a_len[0]  = r0_len;
    assign a_lox[0]  = r0_lox;
    assign a_loy[0]  = r0_loy;
    assign a_qx[0]   = '0;
    assign a_qy[0]   = '0;
    assign a_meta[0] = r0_meta;
    assign a_vld[0]  = r0_vld;

    genvar j;
    generate
        for (j = 0; j < NS; j++) begin : g_stage
            logic [LEN_W:0] n_sx, n_sy;

            assign n_sx = div_step(a_remx[j], a_lox[j][NF-j], a_len[j]);
            assign n_sy = div_step(a_remy[j], a_loy[j][NF-j], a_len[j]);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[j] <= 1'b0;
                end else if (i_en) begin
                    r_vld[j] <= a_vld[j];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_remx[j] <= n_sx[LEN_W-1:0];
                    r_remy[j] <= n_sy[LEN_W-1:0];
                    r_qx[j]   <= {a_qx[j][NF-1:0], n_sx[LEN_W]};
                    r_qy[j]   <= {a_qy[j][NF-1:0], n_sy[LEN_W]};
                    r_len[j]  <= a_len[j];
                    r_lox[j]  <= a_lox[j];
                    r_loy[j]  <= a_loy[j];
                    r_meta[j] <= a_meta[j];
                end
            end

            assign a_remx[j+1] = r_remx[j];
            assign a_remy[j+1] = r_remy[j];
            assign a_len[j+1]  = r_len[j];
            assign a_lox[j+1]  = r_lox[j];
            assign a_loy[j+1]  = r_loy[j];
            assign a_qx[j+1]   = r_qx[j];
            assign a_qy[j+1]   = r_qy[j];
            assign a_meta[j+1] = r_meta[j];
            assign a_vld[j+1]  = r_vld[j];
        end
    endgenerate

    assign o_valid = a_vld[NS];
    assign o_qx    = a_qx[NS];
    assign o_qy    = a_qy[NS];
    assign o_meta  = a_meta[NS];

endmodule

// File: sv/primitive_pair_collision_test.sv
// Top level of the primitive pair collision test: stream ports, front end,
// square root and divider pipelines, output register.
// Depends on ppct_pkg, ppct_front, ppct_sqrt and ppct_div.
//
//  channel   dir  tdata                                     tuser
//  s_axis    in   first/second x,y; half widths/heights     command
//  m_axis    out  collided, normal_x, normal_y              -
//
// The pipeline is seven front-end stages, one stage per square root bit, one
// setup stage and one stage per quotient bit in the divider, and the output
// register. One transaction is accepted per cycle while the pipeline is not
// held. The whole pipeline advances together and holds only while the output
// register holds an untaken result.
// Reset is synchronous and clears the valid bits only; no clearing pass.
module primitive_pair_collision_test import ppct_pkg::*; #(
    parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // first_x, first_y, second_x, second_y, first_half_width,
    // first_half_height, second_half_width, second_half_height, zero pad
    input  logic [((8*COORD_WIDTH-4+7)/8)*8-1:0] i_s_axis_tdata,
    // command
    input  logic [1:0] i_s_axis_tuser,
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // collided, normal_x, normal_y, zero pad
    output logic [((2*NORMAL_FRAC_BITS+5+7)/8)*8-1:0] o_m_axis_tdata
);

    localparam int CW      = COORD_WIDTH;
    localparam int NF      = NORMAL_FRAC_BITS;
    localparam int NW      = NF + 2;
    localparam int OUT_TDW = ((2*NF + 5 + 7) / 8) * 8;
    localparam logic signed [NW-1:0] ONE = NW'(1) << NF;

    logic en;

    // ---------------- unpack the input transaction
    t_cmd                 in_cmd;
    logic signed [CW-1:0] in_x1, in_y1, in_x2, in_y2;
    logic [CW-2:0]        in_hw1, in_hh1, in_hw2, in_hh2;

    assign in_cmd = t_cmd'(i_s_axis_tuser);
    assign in_x1  = i_s_axis_tdata[0*CW +: CW];
    assign in_y1  = i_s_axis_tdata[1*CW +: CW];
    assign in_x2  = i_s_axis_tdata[2*CW +: CW];
    assign in_y2  = i_s_axis_tdata[3*CW +: CW];
    assign in_hw1 = i_s_axis_tdata[4*CW + 0*(CW-1) +: CW-1];
    assign in_hh1 = i_s_axis_tdata[4*CW + 1*(CW-1) +: CW-1];
    assign in_hw2 = i_s_axis_tdata[4*CW + 2*(CW-1) +: CW-1];
    assign in_hh2 = i_s_axis_tdata[4*CW + 3*(CW-1) +: CW-1];

    // ---------------- pipeline
    logic             f_valid, s_valid, d_valid;
    logic [SQ_W-1:0]  f_len_sq;
    logic [NRM_W-1:0] f_ux, f_uy, s_ux, s_uy;
    logic [LEN_W-1:0] s_len;
    t_meta            f_meta, s_meta, d_meta;
    logic [NF:0]      d_qx, d_qy;

    ppct_front #(.CW(CW)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_s_axis_tvalid),
        .i_cmd    (in_cmd),
        .i_x1     (in_x1),
        .i_y1     (in_y1),
        .i_x2     (in_x2),
        .i_y2     (in_y2),
        .i_hw1    (in_hw1),
        .i_hh1    (in_hh1),
        .i_hw2    (in_hw2),
        .i_hh2    (in_hh2),
        .o_valid  (f_valid),
        .o_len_sq (f_len_sq),
        .o_ux     (f_ux),
        .o_uy     (f_uy),
        .o_meta   (f_meta)
    );

    ppct_sqrt u_sqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (f_valid),
        .i_len_sq (f_len_sq),
        .i_ux     (f_ux),
        .i_uy     (f_uy),
        .i_meta   (f_meta),
        .o_valid  (s_valid),
        .o_len    (s_len),
        .o_ux     (s_ux),
        .o_uy     (s_uy),
        .o_meta   (s_meta)
    );

    ppct_div #(.NF(NF)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_valid),
        .i_len   (s_len),
        .i_ux    (s_ux),
        .i_uy    (s_uy),
        .i_meta  (s_meta),
        .o_valid (d_valid),
        .o_qx    (d_qx),
        .o_qy    (d_qy),
        .o_meta  (d_meta)
    );

    // ---------------- assemble the normal
    logic signed [NW-1:0] n_nx, n_ny, n_qx, n_qy;

    assign n_qx = $signed({1'b0, d_qx});
    assign n_qy = $signed({1'b0, d_qy});

    always_comb begin
        if (d_meta.use_unit) begin
            n_nx = d_meta.neg_x ? -n_qx : n_qx;
        end else begin
            case (d_meta.fix_x)
                AX_POS:  n_nx = ONE;
                AX_NEG:  n_nx = -ONE;
                default: n_nx = '0;
            endcase
        end
        if (d_meta.use_unit) begin
            n_ny = d_meta.neg_y ? -n_qy : n_qy;
        end else begin
            case (d_meta.fix_y)
                AX_POS:  n_ny = ONE;
                AX_NEG:  n_ny = -ONE;
                default: n_ny = '0;
            endcase
        end
    end

    // ---------------- output register; advance everything when it frees up
    logic                 r_out_valid, r_collided;
    logic signed [NW-1:0] r_nx, r_ny;

    assign en = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_collided <= d_meta.hit;
            r_nx       <= n_nx;
            r_ny       <= n_ny;
        end
    end

    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDW - 1 - 2*NW){1'b0}}, r_ny, r_nx, r_collided};

    // ---------------- checks
    a_miss_zero_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_collided |-> (r_nx == '0) && (r_ny == '0))
        else $error("normal not zero for a miss");

    a_normal_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_nx <= ONE) && (r_nx >= -ONE) && (r_ny <= ONE) && (r_ny >= -ONE))
        else $error("normal component out of unit range");

    a_stall_only_on_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> r_out_valid && !i_m_axis_tready)
        else $error("input stalled without a held result");

    a_stall_holds_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_nx) && $stable(r_ny) && $stable(r_collided))
        else $error("held result changed during a stall");

endmodule
